// ===== sv/commit_gap_leash_estimator_macros.svh =====
// Assertion macros shared by the commit gap leash estimator RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef COMMIT_GAP_LEASH_ESTIMATOR_MACROS_SVH
`define COMMIT_GAP_LEASH_ESTIMATOR_MACROS_SVH

// Property that must hold on every clock edge out of reset
`define CGLE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define CGLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CGLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cgle_pkg.sv =====
// Shared types and fixed field widths for the commit gap leash estimator.
// No dependencies; imported by the gap cell and the top level.
`timescale 1ns / 1ps

package cgle_pkg;

    // Field widths of the commit and result transactions
    localparam int TS_W    = 32;
    localparam int AVG_W   = 32;
    localparam int LEASH_W = 35;

    // What one gap cell hands to its right-hand neighbor
    typedef struct packed {
        logic            gt;   // incoming gap beats this cell's entry
        logic [TS_W-1:0] val;  // entry currently held
    } cgle_link_t;

endpackage

// ===== sv/cgle_gap_cell.sv =====
// One cell of the descending top-gap list.
// Depends on cgle_pkg for the neighbor link type.
`timescale 1ns / 1ps

module cgle_gap_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     clear,
    input  logic [cgle_pkg::TS_W-1:0] gap,
    input  cgle_pkg::cgle_link_t     left,
    output cgle_pkg::cgle_link_t     link
);
    import cgle_pkg::*;

    logic [TS_W-1:0] val_reg;
    logic [TS_W-1:0] val_next;
    logic            gt;

    // Ties go behind equal entries: strict compare
    assign gt = (gap > val_reg);

    // Take the gap at the insert point, shift in from the left past it; clear empties the cell
    always_comb
    begin
        if (clear)
        begin
            val_next = '0;
        end
        else if (gt)
        begin
            val_next = left.gt ? left.val : gap;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign link.gt  = gt;
    assign link.val = val_reg;

endmodule

// ===== sv/cgle_const_div.sv =====
// Two-stage divide by a constant: reciprocal multiply in 16-bit chunks, then
// combine and shift. Self-contained, no package dependency.
`timescale 1ns / 1ps

module cgle_const_div #(
    parameter int X_W     = 32,
    parameter int DIVISOR = 16
) (
    input  logic           clk,
    input  logic           pp_en,
    input  logic           q_en,
    input  logic [X_W-1:0] x,
    output logic [X_W-1:0] q
);
    // floor(x/D) = (x*M) >> (X_W+L), M = floor(2^(X_W+L)/D)+1, L = ceil(log2 D)
    localparam int          L      = $clog2(DIVISOR);
    localparam int          M_W    = X_W + 2;
    localparam logic [63:0] M64    = ((64'd1 << (X_W + L)) / 64'(DIVISOR)) + 64'd1;
    localparam logic [M_W-1:0] M   = M64[M_W-1:0];
    localparam int          CH_W   = 16;
    localparam int          NCH    = (X_W + CH_W - 1) / CH_W;
    localparam int          PAD_W  = NCH * CH_W;
    localparam int          PP_W   = CH_W + M_W;
    localparam int          PROD_W = PAD_W + M_W;
    localparam int          SHIFT  = X_W + L;

    logic [PAD_W-1:0]  x_pad;
    logic [PP_W-1:0]   pp_reg [NCH];
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    q_reg;
    logic [X_W-1:0]    q_next;

    assign x_pad = PAD_W'(x);

    // Partial products, one per chunk
    always_ff @(posedge clk)
    begin
        if (pp_en)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                pp_reg[c] <= PP_W'(x_pad[c*CH_W +: CH_W]) * PP_W'(M);
            end
        end
    end

    // Recombine and drop the fraction
    always_comb
    begin
        prod = '0;
        for (int c = 0; c < NCH; c++)
        begin
            prod = prod + (PROD_W'(pp_reg[c]) << (c * CH_W));
        end
        q_next = X_W'(prod >> SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (q_en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== sv/commit_gap_leash_estimator.sv =====
// Commit gap leash estimator: six-stage pipeline, one commit per cycle sustained
// unless result_stall holds it. A result passes stages a to e and the output
// register; each stage holds one transaction and moves on as soon as the stage
// after it frees up. The top-gap list is a row of cells updated once per commit.
// Reset (rst_n low, asynchronous) clears counters, timestamps and the gap list,
// sets the average spacing to 1 and enables the estimator; no clearing pass.
`timescale 1ns / 1ps
`include "commit_gap_leash_estimator_macros.svh"

module commit_gap_leash_estimator #(
    parameter int TOP_GAPS       = 8,
    parameter int SPACING_PERIOD = 16,
    parameter int GAP_WINDOW     = 32,
    parameter int IGNORED_TOP    = 2,
    parameter int AVERAGED_GAPS  = 6,
    parameter int TS_BITS        = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_write_en,
    input  logic                         cfg_write_data,
    // commit channel
    input  logic                         commit_valid,
    output logic                         commit_stall,
    input  logic [cgle_pkg::TS_W-1:0]    commit_timestamp,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         sparsity_update,
    output logic [cgle_pkg::AVG_W-1:0]   avg_sparsity,
    output logic                         leash_update,
    output logic [cgle_pkg::LEASH_W-1:0] time_leash
);
    import cgle_pkg::*;

    localparam int TS_USED  = (TS_BITS < TS_W) ? TS_BITS : TS_W;
    localparam logic [TS_W-1:0] TS_MASK = {TS_W{1'b1}} >> (TS_W - TS_USED);
    localparam int SP_CNT_W = (SPACING_PERIOD > 1) ? $clog2(SPACING_PERIOD) : 1;
    localparam int GW_CNT_W = (GAP_WINDOW > 1) ? $clog2(GAP_WINDOW) : 1;
    localparam logic [SP_CNT_W-1:0] SP_LAST = SP_CNT_W'(SPACING_PERIOD - 1);
    localparam logic [GW_CNT_W-1:0] GW_LAST = GW_CNT_W'(GAP_WINDOW - 1);
    localparam int SUM_W    = TS_W + $clog2(TOP_GAPS);
    localparam int MUL_W    = SUM_W + $clog2(TOP_GAPS + 1);

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a transaction when it is empty or
    // the stage after it is moving
    // ------------------------------------------------------------------
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, out_vld_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    assign rdy6 = !out_vld_reg || !result_stall;
    assign rdy5 = !e_vld_reg || rdy6;
    assign rdy4 = !d_vld_reg || rdy5;
    assign rdy3 = !c_vld_reg || rdy4;
    assign rdy2 = !b_vld_reg || rdy3;
    assign rdy1 = !a_vld_reg || rdy2;

    assign ld1 = commit_valid && rdy1;
    assign ld2 = a_vld_reg && rdy2;
    assign ld3 = b_vld_reg && rdy3;
    assign ld4 = c_vld_reg && rdy4;
    assign ld5 = d_vld_reg && rdy5;
    assign ld6 = e_vld_reg && rdy6;

    assign commit_stall = !rdy1;
    assign result_valid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) a_vld_reg   <= commit_valid;
            if (rdy2) b_vld_reg   <= a_vld_reg;
            if (rdy3) c_vld_reg   <= b_vld_reg;
            if (rdy4) d_vld_reg   <= c_vld_reg;
            if (rdy5) e_vld_reg   <= d_vld_reg;
            if (rdy6) out_vld_reg <= e_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Enable register
    // ------------------------------------------------------------------
    logic adaptive_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adaptive_enable_reg <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            adaptive_enable_reg <= cfg_write_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: counters, span and gap
    // ------------------------------------------------------------------
    logic [SP_CNT_W-1:0] sp_cnt_reg, sp_cnt_next;
    logic [GW_CNT_W-1:0] gw_cnt_reg, gw_cnt_next;
    logic [TS_W-1:0]     sp_start_reg, sp_start_next;
    logic [TS_W-1:0]     prev_ts_reg, prev_ts_next;
    logic [TS_W-1:0]     ts;
    logic                sp_hit, gw_hit;
    logic                a_supd_reg, a_supd_next;
    logic                a_lend_reg, a_lend_next;
    logic [TS_W-1:0]     a_span_reg, a_span_next;
    logic [TS_W-1:0]     a_gap_reg, a_gap_next;

    assign ts     = commit_timestamp & TS_MASK;
    assign sp_hit = (sp_cnt_reg == SP_LAST);
    assign gw_hit = (gw_cnt_reg == GW_LAST);

    always_comb
    begin
        sp_cnt_next   = sp_cnt_reg;
        gw_cnt_next   = gw_cnt_reg;
        sp_start_next = sp_start_reg;
        prev_ts_next  = prev_ts_reg;
        a_supd_next   = 1'b0;
        a_lend_next   = 1'b0;
        // negative span clamps to an average of 1, same as a zero quotient
        a_span_next   = (ts >= sp_start_reg) ? (ts - sp_start_reg) : '0;
        // a zero gap never enters the list, so disabled commits carry one
        a_gap_next    = '0;
        if (adaptive_enable_reg)
        begin
            sp_cnt_next  = sp_hit ? '0 : sp_cnt_reg + 1'b1;
            gw_cnt_next  = gw_hit ? '0 : gw_cnt_reg + 1'b1;
            prev_ts_next = ts;
            a_supd_next  = sp_hit;
            a_lend_next  = gw_hit;
            a_gap_next   = (ts >= prev_ts_reg) ? (ts - prev_ts_reg) : '0;
            if (sp_hit)
            begin
                sp_start_next = ts;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_cnt_reg   <= '0;
            gw_cnt_reg   <= '0;
            sp_start_reg <= '0;
            prev_ts_reg  <= '0;
        end
        else if (ld1)
        begin
            sp_cnt_reg   <= sp_cnt_next;
            gw_cnt_reg   <= gw_cnt_next;
            sp_start_reg <= sp_start_next;
            prev_ts_reg  <= prev_ts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            a_supd_reg <= a_supd_next;
            a_lend_reg <= a_lend_next;
            a_span_reg <= a_span_next;
            a_gap_reg  <= a_gap_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sorted insert across the cell row; tail entry/exit values
    // ------------------------------------------------------------------
    cgle_link_t      link [TOP_GAPS];
    cgle_link_t      head_link;
    logic [TS_W-1:0] tail_in, tail_out;

    assign head_link.gt  = 1'b0;
    assign head_link.val = a_gap_reg;

    for (genvar i = 0; i < TOP_GAPS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            cgle_gap_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (ld2),
                .clear (a_lend_reg),
                .gap   (a_gap_reg),
                .left  (head_link),
                .link  (link[i])
            );
        end
        else
        begin : g_body
            cgle_gap_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (ld2),
                .clear (a_lend_reg),
                .gap   (a_gap_reg),
                .left  (link[i-1]),
                .link  (link[i])
            );
        end
    end

    // Value entering the averaged tail and value falling off the end
    if (IGNORED_TOP == 0)
    begin : g_tail_all
        assign tail_in  = link[TOP_GAPS-1].gt ? a_gap_reg : '0;
        assign tail_out = link[TOP_GAPS-1].gt ? link[TOP_GAPS-1].val : '0;
    end
    else if (IGNORED_TOP < TOP_GAPS)
    begin : g_tail_part
        assign tail_in  = !link[TOP_GAPS-1].gt ? '0 :
                          link[IGNORED_TOP-1].gt ? link[IGNORED_TOP-1].val : a_gap_reg;
        assign tail_out = link[TOP_GAPS-1].gt ? link[TOP_GAPS-1].val : '0;
    end
    else
    begin : g_tail_none
        assign tail_in  = '0;
        assign tail_out = '0;
    end

    logic            b_supd_reg, b_lend_reg;
    logic [TS_W-1:0] b_tin_reg, b_tout_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            b_supd_reg <= a_supd_reg;
            b_lend_reg <= a_lend_reg;
            b_tin_reg  <= tail_in;
            b_tout_reg <= tail_out;
        end
    end

    // spacing divide: partial products at stage 2, quotient at stage 3
    logic [TS_W-1:0] sp_q;

    cgle_const_div #(
        .X_W     (TS_W),
        .DIVISOR (SPACING_PERIOD)
    ) u_sp_div (
        .clk   (clk),
        .pp_en (ld2),
        .q_en  (ld3),
        .x     (a_span_reg),
        .q     (sp_q)
    );

    // ------------------------------------------------------------------
    // Stage 3: running sum of the averaged tail
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] tail_sum_reg, tail_sum_next;
    logic [SUM_W-1:0] sum_now;
    logic             c_supd_reg, c_lend_reg;
    logic [SUM_W-1:0] c_total_reg;

    assign sum_now       = tail_sum_reg + SUM_W'(b_tin_reg) - SUM_W'(b_tout_reg);
    assign tail_sum_next = b_lend_reg ? '0 : sum_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_sum_reg <= '0;
        end
        else if (ld3)
        begin
            tail_sum_reg <= tail_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            c_supd_reg  <= b_supd_reg;
            c_lend_reg  <= b_lend_reg;
            c_total_reg <= b_lend_reg ? sum_now : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4-5: clamp average, divide tail sum by the averaged count
    // ------------------------------------------------------------------
    logic             d_supd_reg, d_lend_reg;
    logic [AVG_W-1:0] d_avg_reg;
    logic             e_supd_reg, e_lend_reg;
    logic [AVG_W-1:0] e_avg_reg;
    logic [SUM_W-1:0] lq;

    cgle_const_div #(
        .X_W     (SUM_W),
        .DIVISOR (AVERAGED_GAPS)
    ) u_leash_div (
        .clk   (clk),
        .pp_en (ld4),
        .q_en  (ld5),
        .x     (c_total_reg),
        .q     (lq)
    );

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            d_supd_reg <= c_supd_reg;
            d_lend_reg <= c_lend_reg;
            d_avg_reg  <= (sp_q == '0) ? AVG_W'(1) : AVG_W'(sp_q);
        end
        if (ld5)
        begin
            e_supd_reg <= d_supd_reg;
            e_lend_reg <= d_lend_reg;
            e_avg_reg  <= d_avg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: output register; holds the current average spacing
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]   leash_full;
    logic [AVG_W-1:0]   avg_sparsity_reg, avg_sparsity_next;
    logic               out_supd_reg, out_lupd_reg;
    logic [LEASH_W-1:0] time_leash_reg, time_leash_next;

    assign leash_full        = MUL_W'(lq) * MUL_W'(TOP_GAPS);
    assign avg_sparsity_next = e_supd_reg ? e_avg_reg : avg_sparsity_reg;
    assign time_leash_next   = e_lend_reg ? leash_full[LEASH_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_sparsity_reg <= AVG_W'(1);
        end
        else if (ld6)
        begin
            avg_sparsity_reg <= avg_sparsity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld6)
        begin
            out_supd_reg   <= e_supd_reg;
            out_lupd_reg   <= e_lend_reg;
            time_leash_reg <= time_leash_next;
        end
    end

    assign sparsity_update = out_supd_reg;
    assign avg_sparsity    = avg_sparsity_reg;
    assign leash_update    = out_lupd_reg;
    assign time_leash      = time_leash_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic gaps_ordered;

    always_comb
    begin
        gaps_ordered = 1'b1;
        for (int i = 0; i < TOP_GAPS - 1; i++)
        begin
            if (link[i].val < link[i+1].val)
            begin
                gaps_ordered = 1'b0;
            end
        end
    end

    `CGLE_ASSERT_ALWAYS(a_gaps_sorted, clk, rst_n, gaps_ordered, "gap list out of order")
    `CGLE_ASSERT_ALWAYS(a_avg_nonzero, clk, rst_n, avg_sparsity_reg != '0, "zero average")
    `CGLE_ASSERT_NEXT(a_avg_held, clk, rst_n, ld6 && !e_supd_reg, $stable(avg_sparsity_reg), "avg moved without update")
    `CGLE_ASSERT_NEXT(a_tail_cleared, clk, rst_n, ld3 && b_lend_reg, tail_sum_reg == '0, "tail sum not cleared")
    `CGLE_ASSERT_IMPLY(a_empty_takes, clk, rst_n, !a_vld_reg, !commit_stall, "stall with empty first stage")

endmodule
